### hdl/ppa_pkg.sv
// package for the polygon perimeter and area block: widths, limits and sequencer states
package ppa_pkg;

    // geometry and fixed-point format
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_VERTICES = 1024;
    localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);

    // shared multiplier: differences and coordinates are one bit wider than a coordinate
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int SQ_BITS   = 2 * DIFF_BITS;

    // bit-pair square root over the scaled squared distance
    localparam int ROOT_STEPS = COORD_BITS + 1 + FRAC_BITS;
    localparam int ROOT_BITS  = ROOT_STEPS;
    localparam int RAD_BITS   = 2 * ROOT_STEPS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int ITER_BITS  = $clog2(ROOT_STEPS);

    // multiply step sequence: four products, then a fold step for the last one
    localparam int MUL_OPS    = 4;
    localparam int STEP_BITS  = $clog2(MUL_OPS + 1);

    localparam logic [STEP_BITS-1:0] OP_DX_SQ = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] OP_DY_SQ = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] OP_AX_BY = STEP_BITS'(2);
    localparam logic [STEP_BITS-1:0] OP_AY_BX = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0] OP_FOLD  = STEP_BITS'(4);

    // running sums
    localparam int LEN_BITS   = 35;
    localparam int AREA_BITS  = 42;
    localparam int CROSS_BITS = AREA_BITS + 1;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic signed [CROSS_BITS:0] CROSS_LIM =
        (CROSS_BITS + 1)'((64'd1 << AREA_BITS) - 64'd1);

    // stream payload widths
    localparam int IN_DATA_BITS  = 2 * COORD_BITS;
    localparam int OUT_DATA_BITS = LEN_BITS + AREA_BITS + COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_SUM,
        ST_OUT
    } ppa_state_t;

endpackage

### hdl/polygon_perimeter_and_area.sv
// A first vertex is only stored; every later vertex runs the multiply steps, the square root
// loop and a sum step before ready returns, and a last vertex also runs its closing edge
// before the output register loads. A new vertex is taken only in the idle state, once the
// 25-step bit-pair square root loop that follows the shared 17x17 multiplier is through.
// Reset (rst_n low, asynchronous): sums, vertex count and flags clear, closed_mode is 1,
// no result is pending.
module polygon_perimeter_and_area
    import ppa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration: closed_mode
    input  logic                     cfg_wen,
    input  logic                     cfg_wdata,
    // vertex input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // x_coord [15:0], y_coord [31:16]
    input  logic                     s_tlast,   // last_vertex
    // result output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // perimeter_fixed, doubled_area, vertex_count
    output logic                     m_tuser    // count_overflow
);

    // control state
    ppa_state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]       step_reg, step_next;
    logic [ITER_BITS-1:0]       iter_reg, iter_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic                       overflow_reg, overflow_next;
    logic [LEN_BITS-1:0]        length_sum_reg, length_sum_next;
    logic signed [CROSS_BITS-1:0] cross_sum_reg, cross_sum_next;
    logic                       closed_mode_reg, closed_mode_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       closing_reg, closing_next;
    logic                       last_reg, last_next;

    // vertex and edge operands
    logic signed [COORD_BITS-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;

    // arithmetic working registers
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic [SQ_BITS-1:0]          d2_reg, d2_next;
    logic signed [PROD_BITS-1:0] term_reg, term_next;
    logic [RAD_BITS-1:0]         rad_reg, rad_next;
    logic [REM_BITS-1:0]         rem_reg, rem_next;
    logic [ROOT_BITS-1:0]        root_reg, root_next;

    // output register
    logic [LEN_BITS-1:0]   perim_out_reg, perim_out_next;
    logic [AREA_BITS-1:0]  area_out_reg, area_out_next;
    logic [COUNT_BITS-1:0] count_out_reg, count_out_next;
    logic                  ovf_out_reg, ovf_out_next;

    // combinational helpers
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic signed [DIFF_BITS-1:0]  dx, dy, mul_a, mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;
    logic [REM_BITS+1:0]          rem_sh, trial;
    logic [LEN_BITS:0]            len_wide;
    logic [LEN_BITS-1:0]          len_sat;
    logic signed [CROSS_BITS:0]   cross_wide;
    logic signed [CROSS_BITS-1:0] cross_sat, cross_neg;
    logic                         in_accept, out_accept, first_vertex;

    assign in_x = s_tdata[COORD_BITS-1:0];
    assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = out_valid_reg && m_tready;
    assign first_vertex = (count_reg == '0) && !overflow_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {count_out_reg, area_out_reg, perim_out_reg};
    assign m_tuser  = ovf_out_reg;

    // edge differences and the shared multiplier
    assign dx = DIFF_BITS'(ax_reg) - DIFF_BITS'(bx_reg);
    assign dy = DIFF_BITS'(ay_reg) - DIFF_BITS'(by_reg);

    always_comb
    begin
        case (step_reg)
            OP_DX_SQ:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            OP_DY_SQ:
            begin
                mul_a = dy;
                mul_b = dy;
            end
            OP_AX_BY:
            begin
                mul_a = DIFF_BITS'(ax_reg);
                mul_b = DIFF_BITS'(by_reg);
            end
            OP_AY_BX:
            begin
                mul_a = DIFF_BITS'(ay_reg);
                mul_b = DIFF_BITS'(bx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one square root step: bring down two radicand bits, try to subtract 4*root+1
    assign rem_sh = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = (REM_BITS + 2)'({root_reg, 2'b01});

    // saturating perimeter add
    assign len_wide = (LEN_BITS + 1)'(length_sum_reg) + (LEN_BITS + 1)'(root_reg);
    assign len_sat  = len_wide[LEN_BITS] ? LEN_MAX : len_wide[LEN_BITS-1:0];

    // saturating cross sum add
    assign cross_wide = (CROSS_BITS + 1)'(cross_sum_reg) + (CROSS_BITS + 1)'(term_reg);

    always_comb
    begin
        if (cross_wide > CROSS_LIM)
            cross_sat = CROSS_BITS'(CROSS_LIM);
        else if (cross_wide < -CROSS_LIM)
            cross_sat = CROSS_BITS'(-CROSS_LIM);
        else
            cross_sat = cross_wide[CROSS_BITS-1:0];
    end

    assign cross_neg = -cross_sum_reg;

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        iter_next        = iter_reg;
        count_next       = count_reg;
        overflow_next    = overflow_reg;
        length_sum_next  = length_sum_reg;
        cross_sum_next   = cross_sum_reg;
        closed_mode_next = closed_mode_reg;
        out_valid_next   = out_valid_reg;
        closing_next     = closing_reg;
        last_next        = last_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        bx_next          = bx_reg;
        by_next          = by_reg;
        prod_next        = prod_reg;
        d2_next          = d2_reg;
        term_next        = term_reg;
        rad_next         = rad_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        perim_out_next   = perim_out_reg;
        area_out_next    = area_out_reg;
        count_out_next   = count_out_reg;
        ovf_out_next     = ovf_out_reg;

        if (cfg_wen)
            closed_mode_next = cfg_wdata;

        if (out_accept)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    last_next    = s_tlast;
                    closing_next = 1'b0;
                    prev_x_next  = in_x;
                    prev_y_next  = in_y;
                    if (count_reg >= COUNT_BITS'(MAX_VERTICES))
                        overflow_next = 1'b1;
                    else
                        count_next = count_reg + 1'b1;
                    if (first_vertex)
                    begin
                        // first vertex: no edge yet, a lone vertex closes on itself
                        first_x_next = in_x;
                        first_y_next = in_y;
                        if (s_tlast)
                            state_next = ST_OUT;
                    end
                    else
                    begin
                        ax_next    = prev_x_reg;
                        ay_next    = prev_y_reg;
                        bx_next    = in_x;
                        by_next    = in_y;
                        step_next  = OP_DX_SQ;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                prod_next = mul_p;
                // fold in the product of the previous step
                case (step_reg)
                    OP_DY_SQ: d2_next   = SQ_BITS'(prod_reg);
                    OP_AX_BY: d2_next   = d2_reg + SQ_BITS'(prod_reg);
                    OP_AY_BX: term_next = prod_reg;
                    OP_FOLD:  term_next = term_reg - prod_reg;
                    default:  term_next = term_reg;
                endcase
                if (step_reg == OP_FOLD)
                begin
                    rad_next   = {d2_reg, {(2 * FRAC_BITS){1'b0}}};
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                    step_next = step_reg + 1'b1;
            end

            ST_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_BITS'(rem_sh - trial);
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[REM_BITS-1:0];
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                if (iter_reg == ITER_BITS'(ROOT_STEPS - 1))
                    state_next = ST_SUM;
                else
                    iter_next = iter_reg + 1'b1;
            end

            ST_SUM:
            begin
                cross_sum_next = cross_sat;
                // open mode skips the closing edge's length only
                if (!closing_reg || closed_mode_reg)
                    length_sum_next = len_sat;
                if (last_reg && !closing_reg)
                begin
                    closing_next = 1'b1;
                    ax_next      = prev_x_reg;
                    ay_next      = prev_y_reg;
                    bx_next      = first_x_reg;
                    by_next      = first_y_reg;
                    step_next    = OP_DX_SQ;
                    state_next   = ST_MUL;
                end
                else if (last_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            end

            ST_OUT:
            begin
                // load the output register once it is free, then clear the polygon
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    perim_out_next  = length_sum_reg;
                    area_out_next   = cross_sum_reg[CROSS_BITS-1] ?
                                      cross_neg[AREA_BITS-1:0] :
                                      cross_sum_reg[AREA_BITS-1:0];
                    count_out_next  = count_reg;
                    ovf_out_next    = overflow_reg;
                    length_sum_next = '0;
                    cross_sum_next  = '0;
                    count_next      = '0;
                    overflow_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            iter_reg        <= '0;
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            length_sum_reg  <= '0;
            cross_sum_reg   <= '0;
            closed_mode_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
            closing_reg     <= 1'b0;
            last_reg        <= 1'b0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            iter_reg        <= iter_next;
            count_reg       <= count_next;
            overflow_reg    <= overflow_next;
            length_sum_reg  <= length_sum_next;
            cross_sum_reg   <= cross_sum_next;
            closed_mode_reg <= closed_mode_next;
            out_valid_reg   <= out_valid_next;
            closing_reg     <= closing_next;
            last_reg        <= last_next;
            first_x_reg     <= first_x_next;
            first_y_reg     <= first_y_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
        end
    end

    // datapath and output payload registers
    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        prod_reg      <= prod_next;
        d2_reg        <= d2_next;
        term_reg      <= term_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        perim_out_reg <= perim_out_next;
        area_out_reg  <= area_out_next;
        count_out_reg <= count_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    // the overflow flag only rises once the count has reached its ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == COUNT_BITS'(MAX_VERTICES)))
        else $error("overflow flag set below the vertex ceiling");

    // the root loop stops after its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (iter_reg < ITER_BITS'(ROOT_STEPS)))
        else $error("square root step counter out of range");

    // the cross sum stays inside its saturation limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (CROSS_BITS + 1)'(cross_sum_reg) <= CROSS_LIM &&
        (CROSS_BITS + 1)'(cross_sum_reg) >= -CROSS_LIM)
        else $error("cross sum beyond its limit");

    // a result is loaded only when the output register is free or being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !m_tready) |=>
        (state_reg == ST_OUT && out_valid_reg))
        else $error("result loaded over a pending word");

    // the closing edge pass belongs to a last vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        (closing_reg && state_reg != ST_IDLE) |-> last_reg)
        else $error("closing edge without a last vertex");

endmodule

### bench/tb_polygon_perimeter_and_area.sv
// polygon perimeter and area testbench: directed shapes, overflow, saturation, backpressure, random
module tb_polygon_perimeter_and_area;
    timeunit 1ns;
    timeprecision 1ps;

    import ppa_pkg::*;

    localparam int     WATCHDOG_CYCLES = 2000;
    localparam int     SETTLE_CYCLES   = 80;
    localparam int     LONG_HOLD       = 400;
    localparam int     OVERFLOW_RUN    = 1500;
    localparam int     RANDOM_PER_MODE = 120;
    localparam longint PERIM_CAP       = (64'd1 << LEN_BITS) - 1;
    localparam longint CROSS_CAP       = (64'd1 << AREA_BITS) - 1;

    typedef struct packed {
        logic [LEN_BITS-1:0]   perimeter;
        logic [AREA_BITS-1:0]  area2;
        logic [COUNT_BITS-1:0] count;
        logic                  overflow;
    } poly_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wen;
    logic                     cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;

    // expected polygon results, oldest first
    poly_result_t expected_results[$];

    // shadow of the polygon accumulator
    longint first_x, first_y, prev_x, prev_y;
    longint perim_acc, cross_acc;
    int     count_acc;
    bit     overflow_acc;
    bit     closed_mode_q;

    bit     bursty;
    bit     sink_hold_req;
    int     failures;
    int     idle_cycles;

    polygon_perimeter_and_area dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // floor of the edge length with FRAC_BITS fraction bits
    function automatic longint fixed_edge_length(longint ax, longint ay, longint bx, longint by);
        longint     dx;
        longint     dy;
        logic [63:0] rad;
        logic [63:0] root;
        logic [63:0] probe;
        dx = ax - bx;
        dy = ay - by;
        rad = 64'(dx * dx + dy * dy) << (2 * FRAC_BITS);
        root = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rad)
        begin
            probe = probe >> 2;
        end
        while (probe != 64'd0)
        begin
            if (rad >= root + probe)
            begin
                rad = rad - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return longint'(root);
    endfunction

    // perimeter sum saturates at the top of its width
    function automatic void add_length(longint len);
        perim_acc = perim_acc + len;
        if (perim_acc > PERIM_CAP)
        begin
            perim_acc = PERIM_CAP;
        end
    endfunction

    // shoelace sum saturates symmetrically
    function automatic void add_cross(longint ax, longint ay, longint bx, longint by);
        cross_acc = cross_acc + ax * by - ay * bx;
        if (cross_acc > CROSS_CAP)
        begin
            cross_acc = CROSS_CAP;
        end
        if (cross_acc < -CROSS_CAP)
        begin
            cross_acc = -CROSS_CAP;
        end
    endfunction

    // fold one accepted vertex into the shadow state
    function automatic void track_vertex(longint x, longint y, bit last_v);
        poly_result_t r;
        if (count_acc == 0 && !overflow_acc)
        begin
            first_x = x;
            first_y = y;
        end
        else
        begin
            add_length(fixed_edge_length(prev_x, prev_y, x, y));
            add_cross(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (count_acc >= MAX_VERTICES)
        begin
            overflow_acc = 1'b1;
        end
        else
        begin
            count_acc++;
        end
        if (last_v)
        begin
            if (closed_mode_q)
            begin
                add_length(fixed_edge_length(prev_x, prev_y, first_x, first_y));
            end
            add_cross(prev_x, prev_y, first_x, first_y);
            r.perimeter = LEN_BITS'(perim_acc);
            r.area2     = AREA_BITS'(cross_acc < 0 ? -cross_acc : cross_acc);
            r.count     = COUNT_BITS'(count_acc);
            r.overflow  = overflow_acc;
            expected_results.push_back(r);
            first_x = 0;
            first_y = 0;
            prev_x = 0;
            prev_y = 0;
            perim_acc = 0;
            cross_acc = 0;
            count_acc = 0;
            overflow_acc = 1'b0;
        end
    endfunction

    // offer one vertex word and wait for it to be taken
    task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y, input logic last_v);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last_v;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        track_vertex(x, y, last_v);
    endtask

    // stop sending, drain all results, let the block go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // closed_mode register write, block idle
    task automatic write_closed_mode(input bit value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        closed_mode_q = value;
    endtask

    // mix of extremes, small values near zero and full-range values
    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            end
            1, 2:
            begin
                v = int'($urandom_range(0, 31)) - 16;
            end
            default:
            begin
                v = int'($urandom);
            end
        endcase
        return COORD_BITS'(v);
    endfunction

    // mostly short polygons, sometimes longer ones
    task automatic send_random_polygon(inout int sent);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            send_vertex(pick_coord(), pick_coord(), i == n - 1);
        end
        sent += n;
    endtask

    // fixed shapes: single vertex, degenerate edges, both windings, full-range square
    task automatic test_directed_shapes();
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd3, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd4, 1'b1);
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, -16'sd32768, 1'b1);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd4, 1'b0);
        send_vertex(16'sd3, 16'sd0, 1'b1);
        settle_block();
        // open chain perimeter, area still closed
        write_closed_mode(1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd3, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd4, 1'b1);
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        settle_block();
        write_closed_mode(1'b1);
    endtask

    // vertex count past its maximum on a full diagonal zigzag that also saturates the perimeter
    task automatic test_vertex_overflow();
        for (int i = 0; i < OVERFLOW_RUN; i++)
        begin
            if (i % 2 == 0)
            begin
                send_vertex(16'sd32767, 16'sd32767, i == OVERFLOW_RUN - 1);
            end
            else
            begin
                send_vertex(-16'sd32768, -16'sd32768, i == OVERFLOW_RUN - 1);
            end
        end
        settle_block();
    endtask

    // result side holds off while vertices keep coming, then the sender waits for all
    task automatic test_backpressure();
        int sent;
        sent = 0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_random_polygon(sent);
        end
        settle_block();
    endtask

    // random polygons over several mode settings, last phase without idling
    task automatic test_random_polygons();
        int sent;
        bit mode;
        for (int phase = 0; phase < 4; phase++)
        begin
            mode = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            bursty = (phase != 3);
            write_closed_mode(mode);
            sent = 0;
            while (sent < RANDOM_PER_MODE)
            begin
                send_random_polygon(sent);
            end
            if (phase != 3)
            begin
                settle_block();
            end
        end
    endtask

    // result sink with random stall bursts and an occasional long hold
    initial
    begin : result_sink
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                hold_left = LONG_HOLD;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else if (bursty && $urandom_range(0, 6) == 0)
            begin
                idle_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        poly_result_t got;
        poly_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.perimeter = m_tdata[LEN_BITS-1:0];
            got.area2     = m_tdata[LEN_BITS +: AREA_BITS];
            got.count     = m_tdata[LEN_BITS+AREA_BITS +: COUNT_BITS];
            got.overflow  = m_tuser;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t: result word with nothing expected:", $realtime);
                    $display("    perim %h area %h count %0d ovf %b",
                             got.perimeter, got.area2, got.count, got.overflow);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.perimeter !== want.perimeter || got.area2 !== want.area2 ||
                    got.count !== want.count || got.overflow !== want.overflow)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: mismatch: perim exp %h got %h, area exp %h got %h",
                                 $realtime, want.perimeter, got.perimeter, want.area2, got.area2);
                        $display("    count exp %0d got %0d, ovf exp %b got %b",
                                 want.count, got.count, want.overflow, got.overflow);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
            $display("** polygon_perimeter_and_area: FAILED **");
            $finish;
        end
    end

    // reset, tests in turn, drain and verdict
    initial
    begin
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        bursty    = 1'b1;
        sink_hold_req = 1'b0;
        failures  = 0;
        idle_cycles = 0;
        closed_mode_q = 1'b1;
        first_x = 0;
        first_y = 0;
        prev_x = 0;
        prev_y = 0;
        perim_acc = 0;
        cross_acc = 0;
        count_acc = 0;
        overflow_acc = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_shapes();
        test_vertex_overflow();
        test_backpressure();
        test_random_polygons();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (failures == 0)
        begin
            $display("** polygon_perimeter_and_area: PASSED **");
        end
        else
        begin
            $display("** polygon_perimeter_and_area: FAILED **");
        end
        $finish;
    end

endmodule
